FILE: src/drs_pkg.sv
package drs_pkg;

	// width of the geometry registers as written through the config port
	localparam int CFG_W = 13;
	// row counter spans image plus skipped rows, column counter the same for columns / 4
	localparam int ROW_CNT_W = CFG_W + 1;
	localparam int COL_CNT_W = CFG_W - 1;

	localparam int LANE_W = 16;
	localparam int LANES = 4;
	localparam int LANE_SUM_W = LANE_W + 2;

	localparam int ACT_W = 4;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_ROWS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_COLS = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SKIP_ROWS = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SKIP_COLS = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SINGLE_PIXEL = 3'd4;

	localparam logic [CFG_W-1:0] IMAGE_ROWS_RST = 13'd6;
	localparam logic [CFG_W-1:0] IMAGE_COLS_RST = 13'd32;

	typedef enum logic [ACT_W-1:0] {
		ACT_IDLE = 4'd0,
		ACT_ROWSYNC = 4'd1,
		ACT_ROWPHI1 = 4'd2,
		ACT_ROWPHI2 = 4'd3,
		ACT_COLSYNC = 4'd4,
		ACT_COLPHI1 = 4'd5,
		ACT_COLPHI2 = 4'd6,
		ACT_READ = 4'd7,
		ACT_FRAME_END = 4'd8
	} act_t;

	typedef enum logic [11:0] {
		PH_IDLE = 12'b0000_0000_0001,
		PH_SKIPROW = 12'b0000_0000_0010,
		PH_OP_COLSYNC = 12'b0000_0000_0100,
		PH_OP_SKIPCOL = 12'b0000_0000_1000,
		PH_OP_ROWS = 12'b0000_0001_0000,
		PH_ROW_BEGIN = 12'b0000_0010_0000,
		PH_COLSYNC = 12'b0000_0100_0000,
		PH_SKIPCOL = 12'b0000_1000_0000,
		PH_READPHI = 12'b0001_0000_0000,
		PH_READ = 12'b0010_0000_0000,
		PH_FINAL = 12'b0100_0000_0000,
		PH_END = 12'b1000_0000_0000
	} phase_t;

endpackage

FILE: src/detector_readout_sequencer.sv
// Frame sequencer for a four-lane detector readout. A word with tuser low starts a
// frame and returns row sync; each word with tuser high returns the next clocking
// action (row phases, column sync, column phases, reads) and finally frame end with
// the wrapping sum of all lane samples taken on read actions. Every input word gives
// exactly one output word. Throughput is one word per clock while m_tready is high:
// a word is held in the input register, and the sequencer state and running sum
// update as it moves to the output register. Geometry registers are written through the
// APB port; the user must write them only while no word is in flight (not enforced).
// Row and column counts saturate at MAX_ROWS and MAX_COLS; column counts are used divided by four.
module detector_readout_sequencer
	import drs_pkg::*;
#(
	parameter int MAX_ROWS = 4096,
	parameter int MAX_COLS = 4096,
	parameter int SUM_WIDTH = 24
) (
	input logic clk,
	input logic arst_n,

	input logic s_tvalid,
	output logic s_tready,
	input logic [LANES*LANE_W-1:0] s_tdata, // lane0_sample, lane1_sample, lane2_sample, lane3_sample
	input logic s_tuser, // mode

	output logic m_tvalid,
	input logic m_tready,
	output logic [((ACT_W+SUM_WIDTH+7)/8)*8-1:0] m_tdata, // action, frame_sum
	output logic m_tlast, // frame_last

	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready
);

	localparam int OUT_W = ((ACT_W + SUM_WIDTH + 7) / 8) * 8;

	// config registers
	logic [CFG_W-1:0] image_rows_q, image_cols_q, skip_rows_q, skip_cols_q;
	logic single_pixel_q;
	logic [CFG_W-1:0] wval;
	logic [CFG_W-1:0] wrows_sat, wcols_sat;
	logic cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wval = pwdata[CFG_W-1:0];
	assign wrows_sat = (32'(wval) > 32'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : wval;
	assign wcols_sat = (32'(wval) > 32'(MAX_COLS)) ? CFG_W'(MAX_COLS) : wval;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q <= IMAGE_ROWS_RST;
			image_cols_q <= IMAGE_COLS_RST;
			skip_rows_q <= '0;
			skip_cols_q <= '0;
			single_pixel_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_IMAGE_ROWS: image_rows_q <= wrows_sat;
				REG_IMAGE_COLS: image_cols_q <= wcols_sat;
				REG_SKIP_ROWS: skip_rows_q <= wrows_sat;
				REG_SKIP_COLS: skip_cols_q <= wcols_sat;
				REG_SINGLE_PIXEL: single_pixel_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_IMAGE_ROWS: prdata = APB_DATA_W'(image_rows_q);
			REG_IMAGE_COLS: prdata = APB_DATA_W'(image_cols_q);
			REG_SKIP_ROWS: prdata = APB_DATA_W'(skip_rows_q);
			REG_SKIP_COLS: prdata = APB_DATA_W'(skip_cols_q);
			REG_SINGLE_PIXEL: prdata = APB_DATA_W'(single_pixel_q);
			default: prdata = '0;
		endcase
	end

	// input register
	logic valid_s1;
	logic mode_s1;
	logic [LANES*LANE_W-1:0] lanes_s1;
	logic adv;
	logic out_valid_q;

	assign adv = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser;
			lanes_s1 <= s_tdata;
		end
	end

	// sequencer state
	phase_t phase_q, phase_n;
	logic [ROW_CNT_W-1:0] row_q, row_n, row_inc, nrows;
	logic [COL_CNT_W-1:0] col_q, col_n, cskip, ncols;
	logic [SUM_WIDTH-1:0] sum_q, sum_n, sum_add;
	logic [LANE_SUM_W-1:0] lane_total;
	act_t act_n;
	logic last_n;
	logic row_skip_left, rows_left, rows_left_inc, cskip_left, cols_left;
	act_t row_ph, row_ph_inc, col_ph;

	assign nrows = ROW_CNT_W'(image_rows_q) + ROW_CNT_W'(skip_rows_q);
	assign cskip = COL_CNT_W'(skip_cols_q[CFG_W-1:2]);
	assign ncols = cskip + COL_CNT_W'(image_cols_q[CFG_W-1:2]);
	assign row_inc = row_q + ROW_CNT_W'(1);

	assign row_skip_left = row_q < ROW_CNT_W'(skip_rows_q);
	assign rows_left = row_q < nrows;
	assign rows_left_inc = row_inc < nrows;
	assign cskip_left = col_q < cskip;
	assign cols_left = col_q < ncols;

	// odd rows and columns take phase 1
	assign row_ph = row_q[0] ? ACT_ROWPHI1 : ACT_ROWPHI2;
	assign row_ph_inc = row_inc[0] ? ACT_ROWPHI1 : ACT_ROWPHI2;
	assign col_ph = col_q[0] ? ACT_COLPHI1 : ACT_COLPHI2;

	assign lane_total = LANE_SUM_W'(lanes_s1[0*LANE_W +: LANE_W])
		+ LANE_SUM_W'(lanes_s1[1*LANE_W +: LANE_W])
		+ LANE_SUM_W'(lanes_s1[2*LANE_W +: LANE_W])
		+ LANE_SUM_W'(lanes_s1[3*LANE_W +: LANE_W]);
	assign sum_add = sum_q + SUM_WIDTH'(lane_total);

	// phases that emit nothing are folded into the one that follows them
	always_comb begin
		phase_n = phase_q;
		row_n = row_q;
		col_n = col_q;
		sum_n = sum_q;
		act_n = ACT_IDLE;
		last_n = 1'b0;
		if (!mode_s1) begin
			phase_n = PH_SKIPROW;
			row_n = '0;
			col_n = '0;
			sum_n = '0;
			act_n = ACT_ROWSYNC;
		end else begin
			unique case (phase_q)
				PH_SKIPROW: begin
					if (row_skip_left) begin
						row_n = row_inc;
						act_n = row_ph;
					end else if (single_pixel_q) begin
						col_n = '0;
						phase_n = PH_OP_SKIPCOL;
						act_n = ACT_COLSYNC;
					end else if (rows_left) begin
						phase_n = PH_COLSYNC;
						act_n = row_ph;
					end else begin
						sum_n = sum_add;
						phase_n = PH_END;
						act_n = ACT_READ;
					end
				end
				PH_OP_COLSYNC, PH_COLSYNC: begin
					col_n = '0;
					phase_n = (phase_q == PH_OP_COLSYNC) ? PH_OP_SKIPCOL : PH_SKIPCOL;
					act_n = ACT_COLSYNC;
				end
				PH_OP_SKIPCOL, PH_OP_ROWS: begin
					if (phase_q == PH_OP_SKIPCOL && cskip_left) begin
						col_n = col_q + COL_CNT_W'(1);
						act_n = col_ph;
					end else if (rows_left && cols_left) begin
						col_n = col_q + COL_CNT_W'(1);
						sum_n = sum_add;
						phase_n = PH_OP_ROWS;
						act_n = ACT_READ;
					end else begin
						if (rows_left) begin
							row_n = nrows;
						end
						sum_n = sum_add;
						phase_n = PH_END;
						act_n = ACT_READ;
					end
				end
				PH_ROW_BEGIN: begin
					if (rows_left) begin
						phase_n = PH_COLSYNC;
						act_n = row_ph;
					end else begin
						sum_n = sum_add;
						phase_n = PH_END;
						act_n = ACT_READ;
					end
				end
				PH_SKIPCOL, PH_READPHI: begin
					if (phase_q == PH_SKIPCOL && cskip_left) begin
						col_n = col_q + COL_CNT_W'(1);
						act_n = col_ph;
					end else if (cols_left) begin
						phase_n = PH_READ;
						act_n = col_ph;
					end else begin
						// row done, next row begins at once
						row_n = row_inc;
						if (rows_left_inc) begin
							phase_n = PH_COLSYNC;
							act_n = row_ph_inc;
						end else begin
							sum_n = sum_add;
							phase_n = PH_END;
							act_n = ACT_READ;
						end
					end
				end
				PH_READ: begin
					col_n = col_q + COL_CNT_W'(1);
					sum_n = sum_add;
					phase_n = PH_READPHI;
					act_n = ACT_READ;
				end
				PH_FINAL: begin
					sum_n = sum_add;
					phase_n = PH_END;
					act_n = ACT_READ;
				end
				PH_END: begin
					phase_n = PH_IDLE;
					act_n = ACT_FRAME_END;
					last_n = 1'b1;
				end
				PH_IDLE: begin
					act_n = ACT_IDLE;
				end
				default: begin
					phase_n = PH_IDLE;
					act_n = ACT_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			row_q <= '0;
			col_q <= '0;
			sum_q <= '0;
		end else if (adv) begin
			phase_q <= phase_n;
			row_q <= row_n;
			col_q <= col_n;
			sum_q <= sum_n;
		end
	end

	// output register
	act_t act_s2;
	logic [SUM_WIDTH-1:0] frame_sum_s2;
	logic last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2 <= act_n;
			last_s2 <= last_n;
			frame_sum_s2 <= last_n ? sum_q : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = OUT_W'({frame_sum_s2, act_s2});
	assign m_tlast = last_s2;

endmodule

FILE: src/drs_checker.sv
module drs_checker
	import drs_pkg::*;
#(
	parameter int SUM_WIDTH = 24,
	parameter int OUT_W = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic m_tlast
);

	logic [ACT_W-1:0] act;
	logic [SUM_WIDTH-1:0] fsum;

	assign act = m_tdata[ACT_W-1:0];
	assign fsum = m_tdata[ACT_W +: SUM_WIDTH];

	// stalled word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// frame end flag and action agree
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (act == ACT_FRAME_END)))
		else $error("tlast does not match frame end action");

	// sum only shown on frame end
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> fsum == '0)
		else $error("frame sum nonzero outside frame end");

	// a free output slot never blocks the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && $past(!m_tvalid) |-> s_tready)
		else $error("input stalled with empty output");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> act <= ACT_FRAME_END)
		else $error("action code out of range");

endmodule

bind detector_readout_sequencer drs_checker #(
	.SUM_WIDTH(SUM_WIDTH),
	.OUT_W(OUT_W)
) u_drs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);

FILE: tb/sv/detector_readout_sequencer_test.sv
module detector_readout_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import drs_pkg::*;

	localparam int SUM_W = 24;
	localparam int ROW_LIMIT = 4096;
	localparam int COL_LIMIT = 4096;
	localparam logic [0:0] PARITY_BIT = 1'b1;
	localparam bit MODE_START = 1'b0;
	localparam bit MODE_ADVANCE = 1'b1;
	localparam int TARGET_WORDS = 2000;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;

	typedef struct {
		act_t action;
		logic [SUM_W-1:0] frame_sum;
		bit last;
	} readout_word_t;

	class frame_scoreboard;
		int unsigned rows_cfg, cols_cfg, skip_rows_cfg, skip_cols_cfg;
		bit single_cfg;
		phase_t phase;
		int unsigned row_cnt, col_cnt;
		logic [SUM_W-1:0] lane_sum;
		readout_word_t expected_words[$];
		int errors, checked, frames_ended, reads;

		function new();
			rows_cfg = 6;
			cols_cfg = 32;
			skip_rows_cfg = 0;
			skip_cols_cfg = 0;
			single_cfg = 0;
			phase = PH_IDLE;
			row_cnt = 0;
			col_cnt = 0;
			lane_sum = '0;
		endfunction

		function int unsigned clip(logic [CFG_W-1:0] value, int unsigned lim);
			return (value > lim) ? lim : int'(value);
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
			REG_IMAGE_ROWS: rows_cfg = clip(value, ROW_LIMIT);
			REG_IMAGE_COLS: cols_cfg = clip(value, COL_LIMIT);
			REG_SKIP_ROWS: skip_rows_cfg = clip(value, ROW_LIMIT);
			REG_SKIP_COLS: skip_cols_cfg = clip(value, COL_LIMIT);
			REG_SINGLE_PIXEL: single_cfg = value[0];
			default: ;
			endcase
		endfunction

		function act_t row_phase(int unsigned r);
			return ((r & PARITY_BIT) != 0) ? ACT_ROWPHI1 : ACT_ROWPHI2;
		endfunction

		function act_t col_phase(int unsigned c);
			return ((c & PARITY_BIT) != 0) ? ACT_COLPHI1 : ACT_COLPHI2;
		endfunction

		function void take_samples(logic [LANES*LANE_W-1:0] lanes);
			lane_sum = lane_sum + lanes[15:0] + lanes[31:16] + lanes[47:32] + lanes[63:48];
			reads++;
		endfunction

		// walks the phases until one of them produces an action
		function act_t advance(logic [LANES*LANE_W-1:0] lanes, output bit last);
			int unsigned cskip, ncols, nrows;
			act_t result;
			bit done;
			cskip = skip_cols_cfg >> 2;
			ncols = cskip + (cols_cfg >> 2);
			nrows = rows_cfg + skip_rows_cfg;
			last = 0;
			done = 0;
			result = ACT_IDLE;
			while (!done) begin
				case (phase)
				PH_SKIPROW: begin
					if (row_cnt < skip_rows_cfg) begin
						result = row_phase(row_cnt);
						row_cnt++;
						done = 1;
					end else begin
						phase = single_cfg ? PH_OP_COLSYNC : PH_ROW_BEGIN;
					end
				end
				PH_OP_COLSYNC: begin
					col_cnt = 0;
					phase = PH_OP_SKIPCOL;
					result = ACT_COLSYNC;
					done = 1;
				end
				PH_OP_SKIPCOL: begin
					if (col_cnt < cskip) begin
						result = col_phase(col_cnt);
						col_cnt++;
						done = 1;
					end else begin
						phase = PH_OP_ROWS;
					end
				end
				PH_OP_ROWS: begin
					if (row_cnt < nrows && col_cnt < ncols) begin
						col_cnt++;
						take_samples(lanes);
						result = ACT_READ;
						done = 1;
					end else begin
						// column count is never rewound, so the rest of the rows are dropped
						if (row_cnt < nrows) row_cnt = nrows;
						phase = PH_FINAL;
					end
				end
				PH_ROW_BEGIN: begin
					if (row_cnt < nrows) begin
						phase = PH_COLSYNC;
						result = row_phase(row_cnt);
						done = 1;
					end else begin
						phase = PH_FINAL;
					end
				end
				PH_COLSYNC: begin
					col_cnt = 0;
					phase = PH_SKIPCOL;
					result = ACT_COLSYNC;
					done = 1;
				end
				PH_SKIPCOL: begin
					if (col_cnt < cskip) begin
						result = col_phase(col_cnt);
						col_cnt++;
						done = 1;
					end else begin
						phase = PH_READPHI;
					end
				end
				PH_READPHI: begin
					if (col_cnt < ncols) begin
						phase = PH_READ;
						result = col_phase(col_cnt);
						done = 1;
					end else begin
						row_cnt++;
						phase = PH_ROW_BEGIN;
					end
				end
				PH_READ: begin
					col_cnt++;
					take_samples(lanes);
					phase = PH_READPHI;
					result = ACT_READ;
					done = 1;
				end
				PH_FINAL: begin
					take_samples(lanes);
					phase = PH_END;
					result = ACT_READ;
					done = 1;
				end
				PH_END: begin
					phase = PH_IDLE;
					last = 1;
					result = ACT_FRAME_END;
					done = 1;
				end
				default: begin
					phase = PH_IDLE;
					result = ACT_IDLE;
					done = 1;
				end
				endcase
			end
			return result;
		endfunction

		function void note_word(bit mode, logic [LANES*LANE_W-1:0] lanes);
			readout_word_t w;
			bit last;
			if (mode == MODE_START) begin
				lane_sum = '0;
				row_cnt = 0;
				col_cnt = 0;
				phase = PH_SKIPROW;
				w.action = ACT_ROWSYNC;
				last = 0;
			end else begin
				w.action = advance(lanes, last);
			end
			w.last = last;
			w.frame_sum = last ? lane_sum : '0;
			expected_words.push_back(w);
		endfunction

		function void check_word(logic [31:0] data, logic tlast);
			readout_word_t w;
			if (expected_words.size() == 0) begin
				$error("output word with nothing expected: data %h last %b", data, tlast);
				errors++;
				return;
			end
			w = expected_words.pop_front();
			checked++;
			if (data[ACT_W-1:0] !== w.action) begin
				$error("action: expected %0d, got %0d", w.action, data[ACT_W-1:0]);
				errors++;
			end
			if (data[ACT_W +: SUM_W] !== w.frame_sum) begin
				$error("frame_sum: expected %h, got %h", w.frame_sum, data[ACT_W +: SUM_W]);
				errors++;
			end
			if (tlast !== w.last) begin
				$error("frame_last: expected %b, got %b", w.last, tlast);
				errors++;
			end
			if (w.last) frames_ended++;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function bool_active();
			return phase != PH_IDLE;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [LANES*LANE_W-1:0] s_tdata; // lane0_sample, lane1_sample, lane2_sample, lane3_sample
	logic s_tuser; // mode
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata; // action, frame_sum
	logic m_tlast; // frame_last
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	detector_readout_sequencer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	frame_scoreboard sb;
	int words_sent;
	int burst_left;
	bit steady_sender;
	bit hold_req;
	int hold_left;
	int rx_mode;
	int rx_mode_left;
	int rx_tick;
	bit rx_ready_next;
	int idle_cycles;
	bit run_done;
	int settings_run;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic send_word(bit mode, logic [LANES*LANE_W-1:0] lanes);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady_sender && $urandom_range(0, 2) != 0) begin
				gap = $urandom_range(1, 8);
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= lanes;
		do @(posedge clk); while (!s_tready);
		sb.note_word(mode, lanes);
		words_sent++;
	endtask

	function automatic logic [LANES*LANE_W-1:0] random_lanes();
		return {$urandom, $urandom};
	endfunction

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_geometry(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols,
			logic [CFG_W-1:0] srows, logic [CFG_W-1:0] scols, bit single);
		write_reg(REG_IMAGE_ROWS, rows);
		write_reg(REG_IMAGE_COLS, cols);
		write_reg(REG_SKIP_ROWS, srows);
		write_reg(REG_SKIP_COLS, scols);
		write_reg(REG_SINGLE_PIXEL, CFG_W'(single));
		settings_run++;
	endtask

	// stop offering words and wait for every outstanding result
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// one frame: start, then advances until frame end or the cap, with the odd restart, then up to two more advances
	task automatic run_frame(int cap);
		int n;
		send_word(MODE_START, random_lanes());
		n = 0;
		while (sb.bool_active() && n < cap) begin
			if ($urandom_range(0, 59) == 0)
				send_word(MODE_START, random_lanes());
			else
				send_word(MODE_ADVANCE, random_lanes());
			n++;
		end
		repeat ($urandom_range(0, 2)) send_word(MODE_ADVANCE, random_lanes());
	endtask

	function automatic logic [CFG_W-1:0] edge_value();
		case ($urandom_range(0, 3))
		0: return '0;
		1: return CFG_W'(ROW_LIMIT);
		2: return '1;
		default: return CFG_W'($urandom_range(0, 8191));
		endcase
	endfunction

	// receiver: changes its stall pattern now and then, plus one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			rx_ready_next = 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			rx_ready_next = 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(50, 300);
			end
			rx_mode_left--;
			rx_tick++;
			case (rx_mode)
			0: rx_ready_next = 1'b1;
			1: rx_ready_next = ($urandom_range(0, 1) == 1);
			2: rx_ready_next = (rx_tick % 4 == 0);
			default: rx_ready_next = ($urandom_range(0, 3) != 0);
			endcase
		end
		m_tready <= rx_ready_next;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		if (arst_n && !run_done) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("detector_readout_sequencer_test failed");
				$finish;
			end
		end
	end

	initial begin
		int phase_no;
		int cap;
		sb = new();
		words_sent = 0;
		burst_left = 0;
		steady_sender = 0;
		hold_req = 0;
		hold_left = 0;
		rx_mode = 0;
		rx_mode_left = 0;
		rx_tick = 0;
		idle_cycles = 0;
		run_done = 0;
		settings_run = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// normal mode, one skipped row and column, all-ones and all-zero samples
		write_geometry(13'd1, 13'd4, 13'd1, 13'd4, 1'b0);
		send_word(MODE_START, '1);
		repeat (9) send_word(MODE_ADVANCE, '1);
		send_word(MODE_ADVANCE, '0);
		wait_drained();

		// single pixel: reads only on the first image row, then final read
		write_reg(REG_IMAGE_ROWS, 13'd2);
		write_reg(REG_IMAGE_COLS, 13'd8);
		write_reg(REG_SINGLE_PIXEL, 13'd1);
		send_word(MODE_START, '0);
		repeat (8) send_word(MODE_ADVANCE, {4{16'hffff}});
		send_word(MODE_ADVANCE, {16'h0001, 16'h8000, 16'ha5a5, 16'h5a5a});
		// restart in the middle of a frame
		send_word(MODE_START, '1);
		repeat (2) send_word(MODE_ADVANCE, '1);
		send_word(MODE_START, '1);
		repeat (2) send_word(MODE_ADVANCE, '1);

		phase_no = 0;
		while (words_sent < TARGET_WORDS) begin
			wait_drained();
			phase_no++;
			cap = 400;
			steady_sender = ($urandom_range(0, 4) == 0);
			case (phase_no)
			1: write_geometry(13'd4096, 13'd4096, 13'd4096, 13'd4096, 1'b0);
			2: write_geometry('1, '1, '1, '1, 1'b1);
			3: write_geometry('0, '0, '0, '0, 1'b0);
			4: write_geometry('0, '0, '0, '0, 1'b1);
			default: begin
				if ($urandom_range(0, 9) == 0)
					write_geometry(edge_value(), edge_value(), edge_value(), edge_value(),
						$urandom_range(0, 1) == 1);
				else
					write_geometry(CFG_W'($urandom_range(0, 6)),
						CFG_W'($urandom_range(0, 40)),
						CFG_W'($urandom_range(0, 3)), CFG_W'($urandom_range(0, 12)),
						$urandom_range(0, 2) == 0);
			end
			endcase
			if (sb.rows_cfg + sb.skip_rows_cfg > 64 || sb.cols_cfg + sb.skip_cols_cfg > 256)
				cap = 40;
			if (phase_no == 6) begin
				// keep offering while the output is held back so the input backs up
				steady_sender = 1;
				hold_req = 1;
			end
			repeat ($urandom_range(1, 3)) run_frame(cap);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		run_done = 1;
		$display("run covered %0d input words over %0d register settings", words_sent,
			settings_run);
		$display("%0d output words checked, %0d frames completed, %0d read actions",
			sb.checked, sb.frames_ended, sb.reads);
		if (sb.errors == 0) begin
			$display("detector_readout_sequencer_test passed");
		end else begin
			$display("detector_readout_sequencer_test failed");
		end
		$finish;
	end

endmodule

FILE: files.f
src/drs_pkg.sv
src/detector_readout_sequencer.sv
src/drs_checker.sv
tb/sv/detector_readout_sequencer_test.sv
